// ===== hw/rtl/vsws_pkg.sv =====
`timescale 1ns / 1ps
package vsws_pkg;
  localparam int FRAMES = 16;
  localparam int PROCESSES = 4;
  localparam int PAGE_BITS = 16;
  localparam int FIDX_W = $clog2(FRAMES);
  localparam int FCNT_W = $clog2(FRAMES + 1);
  localparam int PID_W = 2;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_TERM = 2'd3;

  localparam logic [2:0] ST_HIT = 3'd0;
  localparam logic [2:0] ST_FAULT = 3'd1;
  localparam logic [2:0] ST_NOFREE = 3'd2;
  localparam logic [2:0] ST_CREATED = 3'd3;
  localparam logic [2:0] ST_TERM = 3'd4;

  localparam logic [1:0] REG_MIN = 2'd0;
  localparam logic [1:0] REG_MAX = 2'd1;
  localparam logic [1:0] REG_THR = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  pid;
    logic [15:0] page_number;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  frame;
    logic [4:0]  resident_count;
    logic        interval_closed;
    logic [31:0] access_count;
    logic [31:0] total_faults;
    logic [31:0] interval_count;
    logic [31:0] resident_sum;
  } rsp_t;

  // one sweep request to the frame table
  localparam logic [2:0] SW_LOOKUP = 3'd0;
  localparam logic [2:0] SW_CLOSE = 3'd1;
  localparam logic [2:0] SW_FREE = 3'd2;
  localparam logic [2:0] SW_COUNT = 3'd3;

  typedef struct packed {
    logic                 start;
    logic [2:0]           mode;
    logic [PID_W-1:0]     pid;
    logic [PAGE_BITS-1:0] page;
  } sweep_cmd_t;

  typedef struct packed {
    logic              done;
    logic              hit;
    logic              have_free;
    logic [FIDX_W-1:0] slot;
    logic [FCNT_W-1:0] count;
  } sweep_rsp_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] a);
    sat_inc = (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
  endfunction
endpackage

// ===== hw/rtl/vsws_stream_if.sv =====
`timescale 1ns / 1ps
interface vsws_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/vsws_frame_table.sv =====
`timescale 1ns / 1ps
module vsws_frame_table (
  input  logic                    clk,
  input  logic                    rst,
  input  vsws_pkg::sweep_cmd_t    cmd,
  output vsws_pkg::sweep_rsp_t    rsp
);
  import vsws_pkg::*;

  logic [FRAMES-1:0] valid;
  logic [FRAMES-1:0] used;
  logic [PID_W-1:0]  owner [FRAMES];
  logic [PAGE_BITS-1:0] page [FRAMES];

  logic              busy;
  logic [2:0]        mode;
  logic [PID_W-1:0]  pid;
  logic [PAGE_BITS-1:0] key;
  logic [FCNT_W-1:0] idx;
  logic              hit;
  logic              have_free;
  logic [FIDX_W-1:0] slot;
  logic [FIDX_W-1:0] free_slot;
  logic [FCNT_W-1:0] count;
  logic              done;

  logic [FIDX_W-1:0] i;
  logic              mine;
  logic              last;
  assign i = idx[FIDX_W-1:0];
  assign mine = valid[i] && owner[i] == pid;
  assign last = idx == FCNT_W'(FRAMES - 1);

  assign rsp.done = done;
  assign rsp.hit = hit;
  assign rsp.have_free = have_free;
  assign rsp.slot = hit ? slot : free_slot;
  assign rsp.count = count;

  // sweep one frame per cycle
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      valid <= '0;
      used <= '0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      mode <= cmd.mode;
      pid <= cmd.pid;
      key <= cmd.page;
      idx <= '0;
      hit <= 1'b0;
      have_free <= 1'b0;
      slot <= '0;
      free_slot <= '0;
      count <= '0;
    end else if (busy) begin
      case (mode)
        SW_LOOKUP: begin
          if (mine && page[i] == key) begin
            hit <= 1'b1;
            slot <= i;
            used[i] <= 1'b1;
          end else if (!have_free && !valid[i]) begin
            have_free <= 1'b1;
            free_slot <= i;
          end
          if ((mine && page[i] == key) || last) begin
            busy <= 1'b0;
            done <= 1'b1;
            // load on miss, if a free frame was found
            if (!(mine && page[i] == key)) begin
              if (have_free) begin
                valid[free_slot] <= 1'b1;
                owner[free_slot] <= pid;
                page[free_slot] <= key;
                used[free_slot] <= 1'b1;
              end else if (!valid[i]) begin
                valid[i] <= 1'b1;
                owner[i] <= pid;
                page[i] <= key;
                used[i] <= 1'b1;
              end
            end
          end
        end
        SW_CLOSE: begin
          if (mine) begin
            if (!used[i]) begin
              valid[i] <= 1'b0;
              owner[i] <= '0;
              page[i] <= '0;
            end else begin
              used[i] <= 1'b0;
              count <= count + FCNT_W'(1);
            end
          end
        end
        SW_FREE: begin
          if (mine) begin
            valid[i] <= 1'b0;
            used[i] <= 1'b0;
            owner[i] <= '0;
            page[i] <= '0;
          end
        end
        default: begin
          if (mine) count <= count + FCNT_W'(1);
        end
      endcase
      idx <= idx + FCNT_W'(1);
      if (mode != SW_LOOKUP && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

// ===== hw/rtl/vsws_page_frame_manager.sv =====
`timescale 1ns / 1ps
// channel  dir  payload
// req      in   opcode, pid, page_number
// rsp      out  status, frame, resident_count, interval_closed, four statistics
// cfg      in   cfg_we, cfg_index, cfg_data
// a request takes one or two sweeps of the frame table, one frame a cycle;
// one request is in work at a time.
// rst is synchronous and clears all frames and counters.
// the result waits in an output register; a new request is taken once it is gone.
module vsws_page_frame_manager (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  vsws_stream_if.sink   req,
  vsws_stream_if.source rsp
);
  import vsws_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_TEST = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [7:0] min_interval, max_interval, fault_threshold;
  logic [2:0] state;
  req_t       cur;
  rsp_t       res;
  logic [31:0] pclk [PROCESSES];
  logic [31:0] pstart [PROCESSES];
  logic [31:0] pfaults [PROCESSES];
  logic [31:0] pacc [PROCESSES];
  logic [31:0] pflt [PROCESSES];
  logic [31:0] pint [PROCESSES];
  logic [31:0] psum [PROCESSES];
  logic        closing;

  sweep_cmd_t cmd;
  sweep_rsp_t srsp;

  vsws_frame_table u_tbl (.clk(clk), .rst(rst), .cmd(cmd), .rsp(srsp));

  logic [PID_W-1:0] p;
  logic [31:0] span;
  logic        close_now;
  assign p = cur.pid;
  assign span = pclk[p] - pstart[p];
  assign close_now = span >= 32'(max_interval) ||
                     (span >= 32'(min_interval) && pfaults[p] >= 32'(fault_threshold));

  assign req.ready = state == S_IDLE;
  assign rsp.valid = state == S_OUT;
  assign rsp.data = res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= 8'd4;
      max_interval <= 8'd6;
      fault_threshold <= 8'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN: min_interval <= cfg_data;
        REG_MAX: max_interval <= cfg_data;
        REG_THR: fault_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // request sequencer
  always_ff @(posedge clk) begin
    cmd.start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      for (int k = 0; k < PROCESSES; k++) begin
        pclk[k] <= '0; pstart[k] <= '0; pfaults[k] <= '0;
        pacc[k] <= '0; pflt[k] <= '0; pint[k] <= '0; psum[k] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur <= req.data;
            res <= '0;
            cmd.pid <= req.data.pid;
            cmd.page <= req.data.page_number;
            cmd.start <= 1'b1;
            closing <= 1'b0;
            if (req.data.opcode == OP_CREATE) begin
              cmd.mode <= SW_COUNT;
              state <= S_SWEEP;
              pclk[req.data.pid] <= '0; pstart[req.data.pid] <= '0;
              pfaults[req.data.pid] <= '0; pacc[req.data.pid] <= '0;
              pflt[req.data.pid] <= '0; pint[req.data.pid] <= '0;
              psum[req.data.pid] <= '0;
              res.status <= ST_CREATED;
            end else if (req.data.opcode == OP_TERM) begin
              cmd.mode <= SW_COUNT;
              closing <= 1'b1;
              state <= S_SWEEP;
            end else begin
              cmd.mode <= SW_LOOKUP;
              pacc[req.data.pid] <= sat_inc(pacc[req.data.pid]);
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          if (srsp.done) begin
            if (srsp.hit) begin
              res.status <= ST_HIT;
              res.frame <= 4'(srsp.slot);
            end else if (srsp.have_free) begin
              res.status <= ST_FAULT;
              res.frame <= 4'(srsp.slot);
              pflt[p] <= sat_inc(pflt[p]);
              pfaults[p] <= sat_inc(pfaults[p]);
            end else begin
              res.status <= ST_NOFREE;
            end
            pclk[p] <= sat_inc(pclk[p]);
            state <= S_TEST;
          end
        end
        S_TEST: begin
          cmd.start <= 1'b1;
          cmd.mode <= close_now ? SW_CLOSE : SW_COUNT;
          closing <= close_now;
          res.interval_closed <= close_now;
          state <= S_SWEEP;
        end
        S_SWEEP: begin
          if (srsp.done) begin
            if (cur.opcode == OP_TERM && cmd.mode == SW_COUNT) begin
              res.status <= ST_TERM;
              res.interval_closed <= 1'b1;
              res.access_count <= pacc[p];
              res.total_faults <= pflt[p];
              res.interval_count <= sat_inc(pint[p]);
              res.resident_sum <= (psum[p] + 32'(srsp.count) < psum[p]) ?
                                  32'hFFFF_FFFF : psum[p] + 32'(srsp.count);
              pclk[p] <= '0; pstart[p] <= '0; pfaults[p] <= '0;
              pacc[p] <= '0; pflt[p] <= '0; pint[p] <= '0; psum[p] <= '0;
              cmd.mode <= SW_FREE;
              cmd.start <= 1'b1;
            end else begin
              if (closing && cur.opcode != OP_TERM) begin
                psum[p] <= (psum[p] + 32'(srsp.count) < psum[p]) ?
                           32'hFFFF_FFFF : psum[p] + 32'(srsp.count);
                pint[p] <= sat_inc(pint[p]);
                pstart[p] <= pclk[p];
                pfaults[p] <= '0;
              end
              res.resident_count <= (cur.opcode == OP_TERM) ? '0 : 5'(srsp.count);
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
